// ===== rtl/cbla_pkg.sv =====
// Shared types and constants for the look-at camera basis pipeline.
package cbla_pkg;

  // Signed width of a raw vector component (position difference or cross product)
  localparam int VW = 34;
  // Root extraction steps (one result bit each) and quotient bits of the divider
  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 15;
  localparam int ONE_Q14   = 16384;
  // Cycles from an accepted word to its result strobe
  localparam int TOTAL_LAT = 174;

  // Configuration address width and register indices
  localparam int AW = 4;
  localparam logic [1:0] REG_UP_X = 2'd0;
  localparam logic [1:0] REG_UP_Y = 2'd1;
  localparam logic [1:0] REG_UP_Z = 2'd2;

  typedef logic signed [VW-1:0] vec_t;
  typedef logic signed [15:0]   q14_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_EYE = 2'd1,
    ST_PAR = 2'd2
  } status_t;

  // Results gathered so far, carried alongside the word
  typedef struct packed {
    q14_t [2:0] back;
    q14_t [2:0] right;
    status_t    st;
  } side_t;

endpackage

// ===== rtl/cbla_cross.sv =====
// Two-stage pipelined cross product of two Q2.14 vectors.
module cbla_cross import cbla_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_vld,
  input  q14_t [2:0] in_a,
  input  q14_t [2:0] in_b,
  input  side_t      in_side,
  output logic       out_vld,
  output vec_t [2:0] out_vec,
  output side_t      out_side
);

  logic signed [31:0] prod_r [6];
  logic               p_vld_r;
  side_t              p_side_r;
  vec_t  [2:0]        vec_r;
  logic               v_vld_r;
  side_t              v_side_r;

  // Form the six partial products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= in_vld;
    end
    prod_r[0] <= $signed(in_a[1]) * $signed(in_b[2]);
    prod_r[1] <= $signed(in_a[2]) * $signed(in_b[1]);
    prod_r[2] <= $signed(in_a[2]) * $signed(in_b[0]);
    prod_r[3] <= $signed(in_a[0]) * $signed(in_b[2]);
    prod_r[4] <= $signed(in_a[0]) * $signed(in_b[1]);
    prod_r[5] <= $signed(in_a[1]) * $signed(in_b[0]);
    p_side_r  <= in_side;
  end

  // Subtract pairs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_vld_r <= 1'b0;
    end else begin
      v_vld_r <= p_vld_r;
    end
    vec_r[0] <= vec_t'(prod_r[0]) - vec_t'(prod_r[1]);
    vec_r[1] <= vec_t'(prod_r[2]) - vec_t'(prod_r[3]);
    vec_r[2] <= vec_t'(prod_r[4]) - vec_t'(prod_r[5]);
    v_side_r <= p_side_r;
  end

  assign out_vld  = v_vld_r;
  assign out_vec  = vec_r;
  assign out_side = v_side_r;

endmodule

// ===== rtl/cbla_norm.sv =====
// Pipelined vector normaliser: scale, root extraction and restoring division.
module cbla_norm import cbla_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_vld,
  input  vec_t [2:0] in_vec,
  input  side_t      in_side,
  output logic       out_vld,
  output q14_t [2:0] out_unit,
  output logic       out_zero,
  output side_t      out_side
);

  typedef struct packed {
    logic       vld;
    logic       zero;
    logic [2:0] neg;
    side_t      side;
  } ctl_t;

  // Magnitude stage
  ctl_t          ctl_a_r, ctl_a_nxt;
  logic [VW-1:0] mag_a_r [3];
  logic [VW-1:0] mag_a_nxt [3];
  // Maximum stage
  ctl_t          ctl_b_r, ctl_b_nxt;
  logic [VW-1:0] mag_b_r [3];
  logic [VW-1:0] s_b_r;
  logic [VW-1:0] s_b_nxt;
  // Right scaling stage
  ctl_t          ctl_c_r;
  logic [29:0]   mag_c_r [3];
  logic [29:0]   mag_c_nxt [3];
  logic [29:0]   s_c_r, s_c_nxt;
  // Left scaling stages
  ctl_t          ctl_d_r;
  logic [29:0]   mag_d_r [3];
  logic [29:0]   mag_d_nxt [3];
  logic [29:0]   s_d_r, s_d_nxt;
  ctl_t          ctl_e_r;
  logic [29:0]   mag_e_r [3];
  logic [29:0]   mag_e_nxt [3];
  logic [29:0]   s_e_r, s_e_nxt;
  // Square stage
  ctl_t          ctl_f_r;
  logic [29:0]   mag_f_r [3];
  logic [59:0]   sq_f_r [3];
  // Root extraction pipeline, index 0 holds the sum of squares
  ctl_t          rt_ctl_r [0:SQ_STEPS];
  logic [63:0]   rt_x_r   [0:SQ_STEPS];
  logic [63:0]   rt_r_r   [0:SQ_STEPS];
  logic [29:0]   rt_m_r   [0:SQ_STEPS][3];
  logic [63:0]   rt_x_nxt [1:SQ_STEPS];
  logic [63:0]   rt_r_nxt [1:SQ_STEPS];
  // Division pipeline, index 0 holds the rounded numerators
  ctl_t          dv_ctl_r [0:DIV_STEPS];
  logic [31:0]   dv_den_r [0:DIV_STEPS];
  logic [45:0]   dv_rem_r [0:DIV_STEPS][3];
  logic [14:0]   dv_q_r   [0:DIV_STEPS][3];
  logic [45:0]   dv_rem_nxt [1:DIV_STEPS][3];
  logic [14:0]   dv_q_nxt   [1:DIV_STEPS][3];
  // Output stage
  ctl_t          o_ctl_r;
  q14_t [2:0]    o_unit_r, o_unit_nxt;

  // Split sign and magnitude
  always_comb begin
    ctl_a_nxt      = '0;
    ctl_a_nxt.vld  = in_vld;
    ctl_a_nxt.side = in_side;
    for (int i = 0; i < 3; i++) begin
      ctl_a_nxt.neg[i] = in_vec[i][VW-1];
      mag_a_nxt[i] = in_vec[i][VW-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
    end
  end

  // Largest magnitude, and flag an all-zero vector
  always_comb begin
    s_b_nxt = mag_a_r[0];
    if (mag_a_r[1] > s_b_nxt) begin
      s_b_nxt = mag_a_r[1];
    end
    if (mag_a_r[2] > s_b_nxt) begin
      s_b_nxt = mag_a_r[2];
    end
    ctl_b_nxt      = ctl_a_r;
    ctl_b_nxt.zero = (s_b_nxt == '0);
  end

  // Halve until the largest magnitude drops below 2^30
  always_comb begin
    logic [2:0] sh;
    if (s_b_r[33]) begin
      sh = 3'd4;
    end else if (s_b_r[32]) begin
      sh = 3'd3;
    end else if (s_b_r[31]) begin
      sh = 3'd2;
    end else if (s_b_r[30]) begin
      sh = 3'd1;
    end else begin
      sh = 3'd0;
    end
    s_c_nxt = 30'(s_b_r >> sh);
    for (int i = 0; i < 3; i++) begin
      mag_c_nxt[i] = 30'(mag_b_r[i] >> sh);
    end
  end

  // Double by 16 and 8 where needed
  always_comb begin
    s_d_nxt = s_c_r;
    for (int i = 0; i < 3; i++) begin
      mag_d_nxt[i] = mag_c_r[i];
    end
    if (s_d_nxt < 30'd16384) begin
      s_d_nxt = s_d_nxt << 16;
      for (int i = 0; i < 3; i++) begin
        mag_d_nxt[i] = mag_d_nxt[i] << 16;
      end
    end
    if (s_d_nxt < 30'd4194304) begin
      s_d_nxt = s_d_nxt << 8;
      for (int i = 0; i < 3; i++) begin
        mag_d_nxt[i] = mag_d_nxt[i] << 8;
      end
    end
  end

  // Double by 4, 2 and 1 where needed
  always_comb begin
    s_e_nxt = s_d_r;
    for (int i = 0; i < 3; i++) begin
      mag_e_nxt[i] = mag_d_r[i];
    end
    if (s_e_nxt < 30'd67108864) begin
      s_e_nxt = s_e_nxt << 4;
      for (int i = 0; i < 3; i++) begin
        mag_e_nxt[i] = mag_e_nxt[i] << 4;
      end
    end
    if (s_e_nxt < 30'd268435456) begin
      s_e_nxt = s_e_nxt << 2;
      for (int i = 0; i < 3; i++) begin
        mag_e_nxt[i] = mag_e_nxt[i] << 2;
      end
    end
    if (s_e_nxt < 30'd536870912) begin
      s_e_nxt = s_e_nxt << 1;
      for (int i = 0; i < 3; i++) begin
        mag_e_nxt[i] = mag_e_nxt[i] << 1;
      end
    end
  end

  // Front stages up to the squares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
      ctl_c_r <= '0;
      ctl_d_r <= '0;
      ctl_e_r <= '0;
      ctl_f_r <= '0;
    end else begin
      ctl_a_r <= ctl_a_nxt;
      ctl_b_r <= ctl_b_nxt;
      ctl_c_r <= ctl_b_r;
      ctl_d_r <= ctl_c_r;
      ctl_e_r <= ctl_d_r;
      ctl_f_r <= ctl_e_r;
    end
    s_b_r <= s_b_nxt;
    s_c_r <= s_c_nxt;
    s_d_r <= s_d_nxt;
    s_e_r <= s_e_nxt;
    for (int i = 0; i < 3; i++) begin
      mag_a_r[i] <= mag_a_nxt[i];
      mag_b_r[i] <= mag_a_r[i];
      mag_c_r[i] <= mag_c_nxt[i];
      mag_d_r[i] <= mag_d_nxt[i];
      mag_e_r[i] <= mag_e_nxt[i];
      mag_f_r[i] <= mag_e_r[i];
      sq_f_r[i]  <= mag_e_r[i] * mag_e_r[i];
    end
  end

  // One root bit per stage
  always_comb begin
    logic [63:0] bitv;
    logic [63:0] trial;
    for (int k = 0; k < SQ_STEPS; k++) begin
      bitv  = 64'd1 << (62 - 2 * k);
      trial = rt_r_r[k] + bitv;
      if (rt_x_r[k] >= trial) begin
        rt_x_nxt[k+1] = rt_x_r[k] - trial;
        rt_r_nxt[k+1] = (rt_r_r[k] >> 1) + bitv;
      end else begin
        rt_x_nxt[k+1] = rt_x_r[k];
        rt_r_nxt[k+1] = rt_r_r[k] >> 1;
      end
    end
  end

  // Sum of squares, then advance the root pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= SQ_STEPS; k++) begin
        rt_ctl_r[k] <= '0;
      end
    end else begin
      rt_ctl_r[0] <= ctl_f_r;
      for (int k = 1; k <= SQ_STEPS; k++) begin
        rt_ctl_r[k] <= rt_ctl_r[k-1];
      end
    end
    rt_x_r[0] <= 64'(sq_f_r[0]) + 64'(sq_f_r[1]) + 64'(sq_f_r[2]);
    rt_r_r[0] <= '0;
    for (int i = 0; i < 3; i++) begin
      rt_m_r[0][i] <= mag_f_r[i];
    end
    for (int k = 1; k <= SQ_STEPS; k++) begin
      rt_x_r[k] <= rt_x_nxt[k];
      rt_r_r[k] <= rt_r_nxt[k];
      for (int i = 0; i < 3; i++) begin
        rt_m_r[k][i] <= rt_m_r[k-1][i];
      end
    end
  end

  // One quotient bit per stage, most significant first
  always_comb begin
    logic [45:0] dsh;
    for (int t = 0; t < DIV_STEPS; t++) begin
      dsh = {14'd0, dv_den_r[t]} << (DIV_STEPS - 1 - t);
      for (int i = 0; i < 3; i++) begin
        dv_q_nxt[t+1][i] = dv_q_r[t][i];
        if (dv_rem_r[t][i] >= dsh) begin
          dv_rem_nxt[t+1][i] = dv_rem_r[t][i] - dsh;
          dv_q_nxt[t+1][i][DIV_STEPS-1-t] = 1'b1;
        end else begin
          dv_rem_nxt[t+1][i] = dv_rem_r[t][i];
        end
      end
    end
  end

  // Rounded numerators, then advance the divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t <= DIV_STEPS; t++) begin
        dv_ctl_r[t] <= '0;
      end
    end else begin
      dv_ctl_r[0] <= rt_ctl_r[SQ_STEPS];
      for (int t = 1; t <= DIV_STEPS; t++) begin
        dv_ctl_r[t] <= dv_ctl_r[t-1];
      end
    end
    dv_den_r[0] <= rt_r_r[SQ_STEPS][31:0];
    for (int i = 0; i < 3; i++) begin
      dv_rem_r[0][i] <= (46'(rt_m_r[SQ_STEPS][i]) << 14)
                        + 46'(rt_r_r[SQ_STEPS][31:1]);
      dv_q_r[0][i]   <= '0;
    end
    for (int t = 1; t <= DIV_STEPS; t++) begin
      dv_den_r[t] <= dv_den_r[t-1];
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[t][i] <= dv_rem_nxt[t][i];
        dv_q_r[t][i]   <= dv_q_nxt[t][i];
      end
    end
  end

  // Clamp to one and restore the sign
  always_comb begin
    logic [15:0] qc;
    for (int i = 0; i < 3; i++) begin
      qc = {1'b0, dv_q_r[DIV_STEPS][i]};
      if (qc > 16'(ONE_Q14)) begin
        qc = 16'(ONE_Q14);
      end
      o_unit_nxt[i] = dv_ctl_r[DIV_STEPS].neg[i] ? q14_t'(-qc) : q14_t'(qc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_ctl_r <= '0;
    end else begin
      o_ctl_r <= dv_ctl_r[DIV_STEPS];
    end
    o_unit_r <= o_unit_nxt;
  end

  assign out_vld  = o_ctl_r.vld;
  assign out_unit = o_unit_r;
  assign out_zero = o_ctl_r.zero;
  assign out_side = o_ctl_r.side;

`ifndef SYNTHESIS
  // Scaling leaves the largest magnitude in [2^29, 2^30)
  a_scaled: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_e_r.vld && !ctl_e_r.zero |-> s_e_r[29])
    else $error("scaled maximum out of range");
  // Root remainder never exceeds twice the root
  a_root: assert property (@(posedge clk) disable iff (!rst_n)
    rt_ctl_r[SQ_STEPS].vld |-> rt_x_r[SQ_STEPS] <= (rt_r_r[SQ_STEPS] << 1))
    else $error("root remainder too large");
`endif

endmodule

// ===== rtl/camera_basis_from_look_at.sv =====
// Throughput: one word per cycle; busy is never raised and results are never held.
// The pipeline holds three normalisers in series, each a 32-step root
// extraction followed by a 15-step restoring divider, one bit per stage.
// Reset (rst_n low, synchronous) empties the pipeline and sets world up to +y.
// Top level: look-at camera basis with APB world-up registers.
module camera_basis_from_look_at import cbla_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [31:0]   in_eye_x,
  input  logic signed [31:0]   in_eye_y,
  input  logic signed [31:0]   in_eye_z,
  input  logic signed [31:0]   in_aim_x,
  input  logic signed [31:0]   in_aim_y,
  input  logic signed [31:0]   in_aim_z,
  output logic                 out_valid,
  output logic signed [15:0]   out_back_x,
  output logic signed [15:0]   out_back_y,
  output logic signed [15:0]   out_back_z,
  output logic signed [15:0]   out_right_x,
  output logic signed [15:0]   out_right_y,
  output logic signed [15:0]   out_right_z,
  output logic signed [15:0]   out_cam_up_x,
  output logic signed [15:0]   out_cam_up_y,
  output logic signed [15:0]   out_cam_up_z,
  output logic [1:0]           out_status,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AW-1:0]        paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  q14_t       up_x_r, up_y_r, up_z_r;
  logic       d_vld_r;
  vec_t [2:0] d_r;

  logic       n1_vld, n2_vld, n3_vld, c1_vld, c2_vld;
  q14_t [2:0] n1_unit, n2_unit, n3_unit;
  logic       n1_zero, n2_zero, n3_zero;
  side_t      n1_side, n2_side, n3_side, c1_side, c2_side;
  side_t      s1, s2;
  vec_t [2:0] c1_vec, c2_vec;
  status_t    fin_st;

  logic       o_vld_r;
  side_t      o_side_r;
  q14_t [2:0] o_up_r;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_x_r <= 16'sd0;
      up_y_r <= 16'sd16384;
      up_z_r <= 16'sd0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_UP_X: up_x_r <= pwdata[15:0];
        REG_UP_Y: up_y_r <= pwdata[15:0];
        REG_UP_Z: up_z_r <= pwdata[15:0];
        default:  ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (paddr[3:2])
      REG_UP_X: prdata = {16'd0, up_x_r};
      REG_UP_Y: prdata = {16'd0, up_y_r};
      REG_UP_Z: prdata = {16'd0, up_z_r};
      default:  prdata = '0;
    endcase
  end

  // Take the word and form eye minus aim
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else begin
      d_vld_r <= start && !busy;
    end
    d_r[0] <= vec_t'(in_eye_x) - vec_t'(in_aim_x);
    d_r[1] <= vec_t'(in_eye_y) - vec_t'(in_aim_y);
    d_r[2] <= vec_t'(in_eye_z) - vec_t'(in_aim_z);
  end

  cbla_norm u_norm_back (
    .clk, .rst_n,
    .in_vld (d_vld_r), .in_vec (d_r), .in_side ('0),
    .out_vld (n1_vld), .out_unit (n1_unit), .out_zero (n1_zero), .out_side (n1_side)
  );

  // Record back and flag a zero view line
  always_comb begin
    s1      = n1_side;
    s1.back = n1_unit;
    s1.st   = n1_zero ? ST_EYE : ST_OK;
  end

  cbla_cross u_cross_right (
    .clk, .rst_n,
    .in_vld (n1_vld), .in_a ({up_z_r, up_y_r, up_x_r}), .in_b (n1_unit),
    .in_side (s1),
    .out_vld (c1_vld), .out_vec (c1_vec), .out_side (c1_side)
  );

  cbla_norm u_norm_right (
    .clk, .rst_n,
    .in_vld (c1_vld), .in_vec (c1_vec), .in_side (c1_side),
    .out_vld (n2_vld), .out_unit (n2_unit), .out_zero (n2_zero), .out_side (n2_side)
  );

  // Record right and flag up parallel to the view line
  always_comb begin
    s2       = n2_side;
    s2.right = n2_unit;
    if (n2_side.st == ST_OK && n2_zero) begin
      s2.st = ST_PAR;
    end
  end

  cbla_cross u_cross_up (
    .clk, .rst_n,
    .in_vld (n2_vld), .in_a (s2.back), .in_b (n2_unit), .in_side (s2),
    .out_vld (c2_vld), .out_vec (c2_vec), .out_side (c2_side)
  );

  cbla_norm u_norm_up (
    .clk, .rst_n,
    .in_vld (c2_vld), .in_vec (c2_vec), .in_side (c2_side),
    .out_vld (n3_vld), .out_unit (n3_unit), .out_zero (n3_zero), .out_side (n3_side)
  );

  // Final status; drop all vectors on any failure
  always_comb begin
    fin_st = n3_side.st;
    if (n3_side.st == ST_OK && n3_zero) begin
      fin_st = ST_PAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else begin
      o_vld_r <= n3_vld;
    end
    o_side_r.st <= fin_st;
    if (fin_st != ST_OK) begin
      o_side_r.back  <= '0;
      o_side_r.right <= '0;
      o_up_r         <= '0;
    end else begin
      o_side_r.back  <= n3_side.back;
      o_side_r.right <= n3_side.right;
      o_up_r         <= n3_unit;
    end
  end

  assign out_valid    = o_vld_r;
  assign out_back_x   = o_side_r.back[0];
  assign out_back_y   = o_side_r.back[1];
  assign out_back_z   = o_side_r.back[2];
  assign out_right_x  = o_side_r.right[0];
  assign out_right_y  = o_side_r.right[1];
  assign out_right_z  = o_side_r.right[2];
  assign out_cam_up_x = o_up_r[0];
  assign out_cam_up_y = o_up_r[1];
  assign out_cam_up_z = o_up_r[2];
  assign out_status   = o_side_r.st;

`ifndef SYNTHESIS
  // Every accepted word gives a strobe after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##TOTAL_LAT out_valid)
    else $error("result strobe missing");
  // A failed word carries no vectors
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_back_x == 16'sd0 && out_back_y == 16'sd0 && out_back_z == 16'sd0 &&
      out_right_x == 16'sd0 && out_right_y == 16'sd0 && out_right_z == 16'sd0 &&
      out_cam_up_x == 16'sd0 && out_cam_up_y == 16'sd0 && out_cam_up_z == 16'sd0)
    else $error("vectors not cleared on failure");
  // Eye equal to aim is reported as such
  a_eye: assert property (@(posedge clk) disable iff (!rst_n)
    n1_vld && n1_zero |-> ##117 out_valid && out_status == ST_EYE)
    else $error("eye equals target not reported");
`endif

endmodule

// ===== tb/cbla_checker.sv =====
// Checker for the look-at camera basis block: predicts each result word and compares it.
module cbla_checker import cbla_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic signed [31:0]  eye_x,
  input  logic signed [31:0]  eye_y,
  input  logic signed [31:0]  eye_z,
  input  logic signed [31:0]  aim_x,
  input  logic signed [31:0]  aim_y,
  input  logic signed [31:0]  aim_z,
  input  logic                out_valid,
  input  q14_t                back_x,
  input  q14_t                back_y,
  input  q14_t                back_z,
  input  q14_t                right_x,
  input  q14_t                right_y,
  input  q14_t                right_z,
  input  q14_t                cup_x,
  input  q14_t                cup_y,
  input  q14_t                cup_z,
  input  logic [1:0]          status,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AW-1:0]       paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  output int                  fail_count,
  output int                  pending
);

  typedef struct {
    q14_t    v[9];
    status_t st;
  } basis_t;

  basis_t basis_q[$];
  q14_t   up_x, up_y, up_z;

  // Integer square root, floor
  function automatic longint unsigned root64(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scale a vector to Q2.14 unit length; zero vector gives 0
  function automatic bit unit_vec(input longint v[3], output q14_t o[3]);
    longint unsigned m[3];
    bit              neg[3];
    longint unsigned s, sum, n, q;
    s = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      m[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
      if (m[i] > s) s = m[i];
      o[i] = '0;
    end
    if (s == 0) return 0;
    while (s >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      s = s >> 1;
    end
    while (s < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      s = s << 1;
    end
    for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
    n = root64(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 14) + (n >> 1)) / n;
      if (q > ONE_Q14) q = ONE_Q14;
      o[i] = neg[i] ? -q[15:0] : q[15:0];
    end
    return 1;
  endfunction

  function automatic void cross_vec(input longint a[3], input longint b[3], output longint r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic basis_t look_at_basis(input longint d[3]);
    basis_t r;
    q14_t   bk[3], rt[3], cu[3];
    longint u[3], t[3], bl[3], rl[3];
    r.st = ST_OK;
    u[0] = up_x;
    u[1] = up_y;
    u[2] = up_z;
    if (!unit_vec(d, bk)) begin
      r.st = ST_EYE;
    end else begin
      for (int i = 0; i < 3; i++) bl[i] = bk[i];
      cross_vec(u, bl, t);
      if (!unit_vec(t, rt)) begin
        r.st = ST_PAR;
      end else begin
        for (int i = 0; i < 3; i++) rl[i] = rt[i];
        cross_vec(bl, rl, t);
        if (!unit_vec(t, cu)) r.st = ST_PAR;
      end
    end
    for (int i = 0; i < 3; i++) begin
      r.v[i]     = (r.st == ST_OK) ? bk[i] : '0;
      r.v[3 + i] = (r.st == ST_OK) ? rt[i] : '0;
      r.v[6 + i] = (r.st == ST_OK) ? cu[i] : '0;
    end
    return r;
  endfunction

  assign pending = basis_q.size();

  // Track world up, queue predictions, compare result words
  always @(posedge clk) begin
    longint d[3];
    basis_t want;
    q14_t   got[9];
    bit     bad;
    if (!rst_n) begin
      up_x <= 16'sd0;
      up_y <= 16'sd16384;
      up_z <= 16'sd0;
      basis_q.delete();
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_UP_X: up_x <= pwdata[15:0];
          REG_UP_Y: up_y <= pwdata[15:0];
          REG_UP_Z: up_z <= pwdata[15:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        d[0] = longint'(eye_x) - longint'(aim_x);
        d[1] = longint'(eye_y) - longint'(aim_y);
        d[2] = longint'(eye_z) - longint'(aim_z);
        basis_q.push_back(look_at_basis(d));
      end
      if (out_valid) begin
        if (basis_q.size() == 0) begin
          if (fail_count < 10) $display("checker: result word with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = basis_q.pop_front();
          got = '{back_x, back_y, back_z, right_x, right_y, right_z, cup_x, cup_y, cup_z};
          bad = (status != want.st);
          for (int i = 0; i < 9; i++) if (got[i] != want.v[i]) bad = 1;
          if (bad) begin
            if (fail_count < 10)
              $display("checker: mismatch exp %p st %0d, got %p st %0d",
                       want.v, want.st, got, status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_camera_basis_from_look_at.sv =====
// Testbench top for the look-at camera basis block: stimulus, APB set-up and verdict.
module tb_camera_basis_from_look_at;
  import cbla_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [31:0] eye_x = 0, eye_y = 0, eye_z = 0, aim_x = 0, aim_y = 0, aim_z = 0;
  logic out_valid;
  q14_t bx, by, bz, rx, ry, rz, ux, uy, uz;
  logic [1:0] st;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [AW-1:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending;
  int idle_pct;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  camera_basis_from_look_at dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_eye_x(eye_x), .in_eye_y(eye_y), .in_eye_z(eye_z),
    .in_aim_x(aim_x), .in_aim_y(aim_y), .in_aim_z(aim_z),
    .out_valid(out_valid),
    .out_back_x(bx), .out_back_y(by), .out_back_z(bz),
    .out_right_x(rx), .out_right_y(ry), .out_right_z(rz),
    .out_cam_up_x(ux), .out_cam_up_y(uy), .out_cam_up_z(uz),
    .out_status(st),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  cbla_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
    .aim_x(aim_x), .aim_y(aim_y), .aim_z(aim_z),
    .out_valid(out_valid),
    .back_x(bx), .back_y(by), .back_z(bz),
    .right_x(rx), .right_y(ry), .right_z(rz),
    .cup_x(ux), .cup_y(uy), .cup_z(uz), .status(st),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending)
  );

  // Hold one pose word on the inputs until it is taken
  task automatic send_pose(input logic [31:0] ex, ey, ez, ax, ay, az);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    eye_x <= ex; eye_y <= ey; eye_z <= ez;
    aim_x <= ax; aim_y <= ay; aim_z <= az;
    do @(posedge clk); while (busy);
  endtask

  // Setup and access phase of one write; the caller releases the bus
  task automatic reg_write(input logic [1:0] idx, input logic [15:0] val);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= AW'(idx) << 2;
    pwdata <= {{16{val[15]}}, val};
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
  endtask

  // Drain the pipeline, then let the latency pass
  task automatic drain;
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (TOTAL_LAT + 10) @(posedge clk);
  endtask

  task automatic set_up(input logic [15:0] x, y, z);
    drain();
    reg_write(REG_UP_X, x);
    reg_write(REG_UP_Y, y);
    reg_write(REG_UP_Z, z);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // Random poses: half full-range, some close pairs, some along the up axis, some coincident
  task automatic random_poses(input int count, input logic [15:0] ux_, uy_, uz_);
    logic [31:0] e[3], a[3];
    int          k, kind;
    for (int n = 0; n < count; n++) begin
      if (n % 32 == 0) idle_pct = (n / 32) % 4 == 0 ? 0 : (n / 32) % 4 == 1 ? 49 :
                                  (n / 32) % 4 == 2 ? 0 : 22;
      if (n == count / 2) drain();
      kind = $urandom_range(9);
      for (int i = 0; i < 3; i++) begin
        e[i] = $urandom;
        a[i] = $urandom;
      end
      if (kind < 3) begin
        for (int i = 0; i < 3; i++) a[i] = e[i] + $urandom_range(8) - 4;
      end else if (kind == 3) begin
        k = $urandom_range(4000) - 2000;
        a[0] = e[0] - k * $signed(ux_);
        a[1] = e[1] - k * $signed(uy_);
        a[2] = e[2] - k * $signed(uz_);
      end else if (kind == 4) begin
        for (int i = 0; i < 3; i++) a[i] = e[i];
      end
      send_pose(e[0], e[1], e[2], a[0], a[1], a[2]);
    end
  endtask

  initial begin
    #20_000_000;
    $display("tb_camera_basis_from_look_at: FAIL");
    $finish;
  end

  initial begin
    int wait_cycles;
    idle_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: coincident, extremes, unit axes, view along up
    send_pose(0, 0, 0, 0, 0, 0);
    send_pose(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000);
    send_pose(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_pose(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000);
    send_pose(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_pose(0, 5 << 16, 0, 0, 0, 0);
    send_pose(0, 0, 0, 0, 32'h7fffffff, 0);
    send_pose(1, 0, 0, 0, 0, 0);
    send_pose(0, 0, 1, 0, 0, 0);
    send_pose(0, 0, 0, 0, 0, 1);
    send_pose(32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, 0, 32'h80000000);
    send_pose(3 << 16, 4 << 16, 0, 0, 0, 0);
    send_pose(1, 1, 1, 0, 0, 0);
    random_poses(130, 0, 16384, 0);

    // Zero up: every non-coincident pose is parallel
    set_up(0, 0, 0);
    send_pose(1, 2, 3, 0, 0, 0);
    send_pose(4, 4, 4, 4, 4, 4);
    random_poses(60, 0, 0, 0);

    set_up(16'hc000, 16'hc000, 16'hc000);
    send_pose(1, 1, 1, 0, 0, 0);
    random_poses(130, 16'hc000, 16'hc000, 16'hc000);

    set_up(16'h4000, 16'h4000, 16'h4000);
    random_poses(130, 16'h4000, 16'h4000, 16'h4000);

    // Out-of-range register values are taken as 16-bit signed
    set_up(16'h8000, 16'h7fff, 16'h0001);
    random_poses(130, 16'h8000, 16'h7fff, 16'h0001);

    set_up(16'($urandom), 16'($urandom), 16'($urandom));
    random_poses(130, 0, 0, 0);

    set_up(0, 0, 16'h4000);
    send_pose(0, 0, 9, 0, 0, 0);
    random_poses(123, 0, 0, 16'h4000);

    // Wind down
    start <= 0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 100_000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (TOTAL_LAT + 20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_camera_basis_from_look_at: PASS");
    end else begin
      $display("tb_camera_basis_from_look_at: FAIL");
    end
    $finish;
  end

endmodule
